>>> rtl/tcprs_pkg.sv
// ----------------------------------------------------------------------------
// tcprs_pkg
// Shared types and codes for the TCP reassembly segment table.
// ----------------------------------------------------------------------------
package tcprs_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;

    localparam int SEQ_W    = 32;
    localparam int LEN_W    = 16;
    localparam int KIND_W   = 2;
    localparam int REASON_W = 3;
    localparam int COUNT_W  = 5;
    localparam int HELD_W   = 20;
    localparam int CAP_W    = 21;
    localparam int CFG_W    = 32;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 64;

    localparam logic [KIND_W-1:0] KIND_PUSH    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CONSUME = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;

    localparam logic [REASON_W-1:0] RSN_NONE    = 3'd0;
    localparam logic [REASON_W-1:0] RSN_EMPTY   = 3'd1;
    localparam logic [REASON_W-1:0] RSN_WINDOW  = 3'd2;
    localparam logic [REASON_W-1:0] RSN_NO_ROOM = 3'd3;
    localparam logic [REASON_W-1:0] RSN_OVERLAP = 3'd4;
    localparam logic [REASON_W-1:0] RSN_FULL    = 3'd5;

    localparam logic CFG_IDX_CAPACITY = 1'b0;
    localparam logic CFG_IDX_INIT_SEQ = 1'b1;

    typedef struct packed {
        logic [SEQ_W-1:0] start;
        logic [LEN_W-1:0] length;
    } seg_entry_t;

endpackage

>>> rtl/tcprs_seg_mem.sv
// ----------------------------------------------------------------------------
// tcprs_seg_mem
// Segment descriptor store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcprs_seg_mem #(
    parameter int DEPTH = tcprs_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  tcprs_pkg::seg_entry_t         wr_data,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output tcprs_pkg::seg_entry_t         rd_data
);
    import tcprs_pkg::*;

    seg_entry_t mem [DEPTH];
    seg_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/tcp_reassembly_segment_table.sv
// ----------------------------------------------------------------------------
// tcp_reassembly_segment_table
// Out-of-order segment descriptor table with push / consume / clear beats.
// ----------------------------------------------------------------------------
// One input beat at a time. Descriptors sit unsorted in a single-port-read
// memory; each step walks the stored entries one read per cycle. A push runs
// the checks, one pass over the stored entries and the write; a push turned
// away by the length, window or room check makes no pass. A consume makes one
// pass per released segment plus a final pass, and refills each hole from the
// last entry. Clear and the unused kind go from the check to the result. The
// result sits in an output register, so the next beat is taken while the
// previous result waits.
// s_tuser: kind. s_tdata: segment_seq[31:0], segment_length[47:32].
// m_tdata: accepted[0], reject_reason[3:1], consumed_count[8:4],
// expected_seq[40:9], bytes_held[60:41], zero above.
module tcp_reassembly_segment_table #(
    parameter int MAX_SEGMENTS = tcprs_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [tcprs_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tcprs_pkg::S_DATA_W-1:0]  s_tdata,  // seq, length
    input  logic [tcprs_pkg::KIND_W-1:0]    s_tuser,  // kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tcprs_pkg::M_DATA_W-1:0]  m_tdata   // acc, reason, count, exp, held
);
    import tcprs_pkg::*;

    localparam int IDX_W  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int HOLD_W = LEN_W + CNT_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CHECK   = 3'd1;
    localparam logic [2:0] ST_SCAN    = 3'd2;
    localparam logic [2:0] ST_MOVE_RD = 3'd3;
    localparam logic [2:0] ST_MOVE_WR = 3'd4;
    localparam logic [2:0] ST_FINISH  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CAP_W-1:0]    cap_reg, cap_next;
    logic [SEQ_W-1:0]    exp_reg, exp_next;
    logic [HOLD_W-1:0]   held_reg, held_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [SEQ_W-1:0]    seq_reg, seq_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [REASON_W-1:0] reason_reg, reason_next;
    logic [CNT_W-1:0]    done_reg, done_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pidx_reg, pidx_next;
    logic [IDX_W-1:0]    dst_reg, dst_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr, rd_addr;
    seg_entry_t          wr_data, rd_data;

    logic [SEQ_W-1:0]    off, ent_off;
    logic                issue, hit, overlap;
    logic [31:0]         room;

    tcprs_seg_mem #(.DEPTH(MAX_SEGMENTS)) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign off     = seq_reg - exp_reg;
    assign ent_off = rd_data.start - exp_reg;
    assign overlap = ({1'b0, off} < ({1'b0, ent_off} + 33'(rd_data.length)))
                  && ({1'b0, ent_off} < ({1'b0, off} + 33'(len_reg)));
    assign issue   = (scan_reg < count_reg);
    assign room    = (32'(cap_reg) > 32'(held_reg)) ? 32'(cap_reg) - 32'(held_reg) : 32'd0;
    assign hit     = (kind_reg == KIND_PUSH) ? overlap : (rd_data.start == exp_reg);

    always_comb begin
        state_next    = state_reg;
        cap_next      = cap_reg;
        exp_next      = exp_reg;
        held_next     = held_reg;
        count_next    = count_reg;
        kind_next     = kind_reg;
        seq_next      = seq_reg;
        len_next      = len_reg;
        reason_next   = reason_reg;
        done_next     = done_reg;
        scan_next     = scan_reg;
        pend_next     = 1'b0;
        pidx_next     = pidx_reg;
        dst_next      = dst_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg[IDX_W-1:0];
        wr_data       = '{start: seq_reg, length: len_reg};
        rd_addr       = scan_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next   = s_tuser;
                    seq_next    = s_tdata[SEQ_W-1:0];
                    len_next    = s_tdata[SEQ_W+LEN_W-1:SEQ_W];
                    reason_next = RSN_NONE;
                    done_next   = '0;
                    scan_next   = '0;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = ST_FINISH;
                if (kind_reg == KIND_PUSH) begin
                    if (len_reg == '0) begin
                        reason_next = RSN_EMPTY;
                    end else if (off >= (32'h8000_0000 - 32'(len_reg))) begin
                        reason_next = RSN_WINDOW;
                    end else if (cap_reg != '0 && 32'(len_reg) > room) begin
                        reason_next = RSN_NO_ROOM;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end else if (kind_reg == KIND_CONSUME) begin
                    state_next = ST_SCAN;
                end else if (kind_reg == KIND_CLEAR) begin
                    count_next = '0;
                    held_next  = '0;
                end
            end
            ST_SCAN: begin
                if (pend_reg && hit) begin
                    if (kind_reg == KIND_PUSH) begin
                        reason_next = RSN_OVERLAP;
                        state_next  = ST_FINISH;
                    end else begin
                        // pop it, refill the hole from the last entry
                        exp_next   = exp_reg + 32'(rd_data.length);
                        held_next  = held_reg - HOLD_W'(rd_data.length);
                        count_next = count_reg - CNT_W'(1);
                        done_next  = done_reg + CNT_W'(1);
                        scan_next  = '0;
                        dst_next   = pidx_reg;
                        if (CNT_W'(pidx_reg) != count_reg - CNT_W'(1)) begin
                            state_next = ST_MOVE_RD;
                        end
                    end
                end else if (issue) begin
                    pend_next = 1'b1;
                    pidx_next = scan_reg[IDX_W-1:0];
                    scan_next = scan_reg + CNT_W'(1);
                end else if (!pend_reg) begin
                    state_next = ST_FINISH;
                    if (kind_reg == KIND_PUSH) begin
                        if (count_reg == CNT_W'(MAX_SEGMENTS)) begin
                            reason_next = RSN_FULL;
                        end else begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            held_next  = held_reg + HOLD_W'(len_reg);
                        end
                    end
                end
            end
            ST_MOVE_RD: begin
                rd_addr    = count_reg[IDX_W-1:0];
                state_next = ST_MOVE_WR;
            end
            ST_MOVE_WR: begin
                wr_en      = 1'b1;
                wr_addr    = dst_reg;
                wr_data    = rd_data;
                state_next = ST_SCAN;
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'({
                        HELD_W'(held_reg),
                        exp_reg,
                        (kind_reg == KIND_CONSUME) ? COUNT_W'(done_reg) : COUNT_W'(0),
                        (kind_reg == KIND_PUSH) ? reason_reg : RSN_NONE,
                        (kind_reg == KIND_PUSH) && (reason_reg == RSN_NONE)
                    });
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cfg_we) begin
            if (cfg_index == CFG_IDX_CAPACITY) begin
                cap_next = cfg_wdata[CAP_W-1:0];
            end else begin
                exp_next   = cfg_wdata;
                count_next = '0;
                held_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cap_reg      <= '0;
            exp_reg      <= '0;
            held_reg     <= '0;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cap_reg      <= cap_next;
            exp_reg      <= exp_next;
            held_reg     <= held_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        seq_reg     <= seq_next;
        len_reg     <= len_next;
        reason_reg  <= reason_next;
        done_reg    <= done_next;
        scan_reg    <= scan_next;
        pidx_reg    <= pidx_next;
        dst_reg     <= dst_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

>>> dv/tb_tcp_reassembly_segment_table.sv
// ----------------------------------------------------------------------------
// tb_tcp_reassembly_segment_table
// Drives push/consume/clear beats with random gaps and output stalls, checks
// every result beat against a behavioral segment table kept in the bench.
// ----------------------------------------------------------------------------
module tb_tcp_reassembly_segment_table;
    import tcprs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSEG = MAX_SEGMENTS_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // highest field first, so the layout matches m_tdata[60:0]
    typedef struct packed {
        logic [HELD_W-1:0]   held;
        logic [SEQ_W-1:0]    exp_seq;
        logic [COUNT_W-1:0]  count;
        logic [REASON_W-1:0] reason;
        logic                acc;
    } seg_result_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq;
        logic [LEN_W-1:0]  len;
        bit                has_exp;
        seg_result_t       exp;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    tcp_reassembly_segment_table u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // bench copy of the table
    logic [SEQ_W-1:0] tbl_start [NSEG];
    logic [LEN_W-1:0] tbl_len [NSEG];
    int unsigned      tbl_count;
    logic [SEQ_W-1:0] next_seq;
    logic [31:0]      held_bytes;
    logic [31:0]      cap_bytes;

    seg_result_t result_q[$];
    bit  errors = 0;
    bit  stim_done = 0;
    int  idle_cycles = 0;
    bit  hold_off = 0;

    function automatic logic [REASON_W-1:0] table_push(logic [31:0] seq, logic [31:0] len);
        logic [31:0] off, room, s;
        int pos;
        if (len == 0) return RSN_EMPTY;
        off = seq - next_seq;
        if (off >= 32'h8000_0000 - len) return RSN_WINDOW;
        if (cap_bytes != 0) begin
            room = (cap_bytes > held_bytes) ? cap_bytes - held_bytes : 0;
            if (len > room) return RSN_NO_ROOM;
        end
        for (int i = 0; i < tbl_count; i++) begin
            s = tbl_start[i] - next_seq;
            if ({32'd0, off} < {32'd0, s} + tbl_len[i] && {32'd0, s} < {32'd0, off} + len)
                return RSN_OVERLAP;
        end
        if (tbl_count >= NSEG) return RSN_FULL;
        pos = 0;
        while (pos < tbl_count && (tbl_start[pos] - next_seq) < off) pos++;
        for (int i = tbl_count; i > pos; i--) begin
            tbl_start[i] = tbl_start[i-1];
            tbl_len[i] = tbl_len[i-1];
        end
        tbl_start[pos] = seq;
        tbl_len[pos] = len;
        tbl_count++;
        held_bytes += len;
        return RSN_NONE;
    endfunction

    function automatic seg_result_t predict_step(logic [KIND_W-1:0] kind, logic [31:0] seq,
                                                 logic [LEN_W-1:0] len);
        seg_result_t r;
        r = '0;
        if (kind == KIND_PUSH) begin
            r.reason = table_push(seq, {16'd0, len});
            r.acc = (r.reason == RSN_NONE);
        end else if (kind == KIND_CONSUME) begin
            while (tbl_count > 0 && tbl_start[0] == next_seq) begin
                next_seq += tbl_len[0];
                held_bytes -= tbl_len[0];
                for (int i = 1; i < tbl_count; i++) begin
                    tbl_start[i-1] = tbl_start[i];
                    tbl_len[i-1] = tbl_len[i];
                end
                tbl_count--;
                r.count++;
            end
        end else if (kind == KIND_CLEAR) begin
            tbl_count = 0;
            held_bytes = 0;
        end
        r.exp_seq = next_seq;
        r.held = held_bytes[HELD_W-1:0];
        return r;
    endfunction

    // valid stays up straight into the next beat when no gap is drawn
    task automatic send_beat(logic [KIND_W-1:0] kind, logic [31:0] seq, logic [LEN_W-1:0] len);
        int unsigned gap;
        gap = $urandom_range(0, 17);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser <= kind;
        s_tdata <= {len, seq};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        result_q.push_back(predict_step(kind, seq, len));
        @(negedge aclk);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        wait_drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_IDX_CAPACITY) cap_bytes = val & 32'h1F_FFFF;
        else begin
            next_seq = val;
            tbl_count = 0;
            held_bytes = 0;
        end
    endtask

    function automatic seg_result_t mk(logic a, logic [2:0] rs, logic [4:0] c,
                                       logic [31:0] e, logic [19:0] h);
        mk = '{acc: a, reason: rs, count: c, exp_seq: e, held: h};
    endfunction

    // stimulus
    initial begin
        stim_row_t rows[$];
        logic [31:0] off;
        int unsigned mode, k;

        cap_bytes = 0;
        next_seq = 0;
        held_bytes = 0;
        tbl_count = 0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, init seq 0, no capacity
        rows = '{
            '{KIND_CONSUME, 32'h0, 16'h0, 1, mk(0, RSN_NONE, 0, 32'h0, 0)},
            '{KIND_PUSH, 32'h0, 16'h0, 1, mk(0, RSN_EMPTY, 0, 32'h0, 0)},
            '{KIND_PUSH, 32'h7FFF_FFFF, 16'h1, 1, mk(0, RSN_WINDOW, 0, 32'h0, 0)},
            '{KIND_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 1, mk(0, RSN_WINDOW, 0, 32'h0, 0)},
            '{KIND_PUSH, 32'h7FFF_FFFE, 16'h1, 1, mk(1, RSN_NONE, 0, 32'h0, 1)},
            '{KIND_PUSH, 32'h100, 16'hFFFF, 0, '0},
            '{KIND_PUSH, 32'h200, 16'h10, 1, mk(0, RSN_OVERLAP, 0, 32'h0, 20'h10000)},
            '{KIND_PUSH, 32'h0, 16'h100, 0, '0},
            '{KIND_PUSH, 32'h1_00FF, 16'h1, 0, '0},
            '{KIND_CONSUME, 32'h0, 16'h0, 0, '0},
            '{KIND_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 0, '0},
            '{KIND_CLEAR, 32'h0, 16'h0, 1, mk(0, RSN_NONE, 0, 32'h1_0100, 0)}
        };
        foreach (rows[i]) begin
            send_beat(rows[i].kind, rows[i].seq, rows[i].len);
            if (rows[i].has_exp && result_q[$] != rows[i].exp) begin
                $error("directed row %0d: predicted %h, table %h", i, rows[i].exp, result_q[$]);
                errors = 1;
            end
        end
        // full table, then capacity at extremes
        for (int i = 0; i < NSEG + 1; i++) send_beat(KIND_PUSH, next_seq + 32'd10 * i + 5, 16'd3);
        send_beat(KIND_CLEAR, 0, 0);
        write_reg(CFG_IDX_CAPACITY, 32'h10_0000);
        send_beat(KIND_PUSH, next_seq + 1, 16'hFFFF);
        write_reg(CFG_IDX_CAPACITY, 32'h1);
        send_beat(KIND_PUSH, next_seq + 70000, 16'h2);
        write_reg(CFG_IDX_INIT_SEQ, 32'hFFFF_FFF0);
        send_beat(KIND_PUSH, 32'hFFFF_FFF0, 16'h1);
        send_beat(KIND_PUSH, 32'hFFFF_FFF1, 16'h1);

        // random phases with different settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_IDX_CAPACITY, 0); write_reg(CFG_IDX_INIT_SEQ, $urandom); end
                1: write_reg(CFG_IDX_CAPACITY, 32'h1F_FFFF);
                2: begin write_reg(CFG_IDX_CAPACITY, $urandom_range(1, 4000));
                   write_reg(CFG_IDX_INIT_SEQ, 32'h7FFF_FF00); end
                3: write_reg(CFG_IDX_CAPACITY, 32'h10_0000);
                4: begin write_reg(CFG_IDX_CAPACITY, 0); write_reg(CFG_IDX_INIT_SEQ, 32'hFFFF_FFFF); end
                default: write_reg(CFG_IDX_INIT_SEQ, 0);
            endcase
            if (ph == 3) hold_off = 1;
            for (int n = 0; n < 240; n++) begin
                mode = $urandom_range(0, 99);
                if (mode < 60) begin
                    // mostly segments near the front, in small slots so they chain
                    k = $urandom_range(0, 7);
                    off = (mode < 10) ? $urandom : k * 32'd64;
                    send_beat(KIND_PUSH, next_seq + off,
                              (mode < 50) ? 16'd64 : LEN_W'($urandom));
                end else if (mode < 88) send_beat(KIND_CONSUME, $urandom, LEN_W'($urandom));
                else if (mode < 92) send_beat(KIND_CLEAR, $urandom, LEN_W'($urandom));
                else if (mode < 94) send_beat(KIND_UNUSED, $urandom, LEN_W'($urandom));
                else send_beat(KIND_PUSH, $urandom, LEN_W'($urandom));
            end
        end
        wait_drain();
        stim_done = 1;
    end

    // receiver: a drawn wait before each beat, with one long hold-off
    initial begin
        int unsigned gap;
        m_tready <= 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_off = 0;
            end
            gap = $urandom_range(0, 17);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // checker
    always @(posedge aclk) begin
        seg_result_t act, want;
        if (aresetn && m_tvalid && m_tready) begin
            act = m_tdata[60:0];
            if (result_q.size() == 0) begin
                $error("result beat with nothing expected: %h", m_tdata);
                errors = 1;
            end else begin
                want = result_q[0];
                result_q.delete(0);
                if (act.acc != want.acc) begin
                    $error("accepted: expected %0d, actual %0d", want.acc, act.acc); errors = 1;
                end
                if (act.reason != want.reason) begin
                    $error("reject_reason: expected %0d, actual %0d", want.reason, act.reason);
                    errors = 1;
                end
                if (act.count != want.count) begin
                    $error("consumed_count: expected %0d, actual %0d", want.count, act.count);
                    errors = 1;
                end
                if (act.exp_seq != want.exp_seq) begin
                    $error("expected_seq: expected %h, actual %h", want.exp_seq, act.exp_seq);
                    errors = 1;
                end
                if (act.held != want.held) begin
                    $error("bytes_held: expected %0d, actual %0d", want.held, act.held);
                    errors = 1;
                end
            end
        end
    end

    // watchdog and end of run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (stim_done) begin
            if (errors == 0 && result_q.size() == 0) $display("simulation ok");
            else $display("simulation failed");
            $finish;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end
endmodule

>>> sim.f
rtl/tcprs_pkg.sv
rtl/tcprs_seg_mem.sv
rtl/tcp_reassembly_segment_table.sv
dv/tb_tcp_reassembly_segment_table.sv
